@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at each rising edge, off during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// property held in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hdl/iou_pkg.sv @@
package iou_pkg;
    localparam int COORD_BITS = 16;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int AREA_W = 2 * COORD_BITS;
    localparam int BOX_W = 2 * DIFF_W;
    localparam int UNI_W = 2 * COORD_BITS + 2;
    localparam int RATIO_W = RATIO_FRAC_BITS + 1;
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int FRONT_STAGES = 3;

    typedef struct packed {
        logic [AREA_W-1:0]        inter;
        logic signed [UNI_W-1:0]  uni;
        logic                     bad;
    } t_item;
endpackage

@@ hdl/box_intersection_over_union_core.sv @@
// Path to o_done: 3 front stages, the queue (write, then registered read),
// 17 restoring divider stages one quotient bit each, 1 output register.
// Throughput: one box pair per cycle while busy is low; the divider is pipelined.
// Reset: synchronous active-low i_rst_n clears all valid bits and the queue.
// Results are strobed by o_done for one cycle; the receiver cannot stall.
module box_intersection_over_union_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_a_left,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_a_bottom,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_a_right,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_a_top,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_b_left,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_b_bottom,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_b_right,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_b_top,
    output logic                                  o_done,
    output logic [iou_pkg::RATIO_W-1:0]           o_iou_ratio,
    output logic [iou_pkg::AREA_W-1:0]            o_overlap_area,
    output logic signed [iou_pkg::UNI_W-1:0]      o_union_area_out,
    output logic                                  o_invalid
);
    logic           n_fv, n_qv, n_full;
    iou_pkg::t_item n_fitem, n_qitem;

    assign busy = n_full;

    iou_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !n_full),
        .i_a_left   (i_a_left),
        .i_a_bottom (i_a_bottom),
        .i_a_right  (i_a_right),
        .i_a_top    (i_a_top),
        .i_b_left   (i_b_left),
        .i_b_bottom (i_b_bottom),
        .i_b_right  (i_b_right),
        .i_b_top    (i_b_top),
        .o_valid    (n_fv),
        .o_item     (n_fitem)
    );

    iou_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_fv),
        .i_item  (n_fitem),
        .o_valid (n_qv),
        .o_item  (n_qitem),
        .o_full  (n_full)
    );

    iou_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (n_qv),
        .i_item           (n_qitem),
        .o_done           (o_done),
        .o_iou_ratio      (o_iou_ratio),
        .o_overlap_area   (o_overlap_area),
        .o_union_area_out (o_union_area_out),
        .o_invalid        (o_invalid)
    );
endmodule

@@ hdl/iou_front.sv @@
module iou_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_a_left,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_a_bottom,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_a_right,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_a_top,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_b_left,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_b_bottom,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_b_right,
    input  logic signed [iou_pkg::COORD_BITS-1:0] i_b_top,
    output logic                                  o_valid,
    output iou_pkg::t_item                        o_item
);
    localparam int CB = iou_pkg::COORD_BITS;
    localparam int DW = iou_pkg::DIFF_W;

    logic signed [CB-1:0] n_xhi, n_yhi, n_xlo, n_ylo;
    logic signed [DW-1:0] n_dx, n_dy;

    logic                 r_v1, r_v2, r_v3;
    logic signed [DW-1:0] r_dx, r_dy, r_aw, r_ah, r_bw, r_bh;
    logic                 r_ov;
    logic [iou_pkg::AREA_W-1:0]       r_inter2;
    logic signed [iou_pkg::BOX_W-1:0] r_aa, r_ba;
    logic signed [iou_pkg::UNI_W:0]   n_uni;
    iou_pkg::t_item                   r_item;

    always_comb begin
        n_xhi = (i_a_right < i_b_right) ? i_a_right : i_b_right;
        n_yhi = (i_a_top < i_b_top) ? i_a_top : i_b_top;
        n_xlo = (i_a_left > i_b_left) ? i_a_left : i_b_left;
        n_ylo = (i_a_bottom > i_b_bottom) ? i_a_bottom : i_b_bottom;
        n_dx  = DW'(n_xhi) - DW'(n_xlo);
        n_dy  = DW'(n_yhi) - DW'(n_ylo);
        n_uni = (iou_pkg::UNI_W+1)'(r_aa) + (iou_pkg::UNI_W+1)'(r_ba)
              - $signed({3'b000, r_inter2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_ov <= (n_dx > 0) && (n_dy > 0);
        r_aw <= DW'(i_a_right) - DW'(i_a_left);
        r_ah <= DW'(i_a_top) - DW'(i_a_bottom);
        r_bw <= DW'(i_b_right) - DW'(i_b_left);
        r_bh <= DW'(i_b_top) - DW'(i_b_bottom);
        r_inter2 <= r_ov ? (r_dx[CB-1:0] * r_dy[CB-1:0]) : '0;
        r_aa <= r_aw * r_ah;
        r_ba <= r_bw * r_bh;
        r_item.inter <= r_inter2;
        r_item.uni   <= n_uni[iou_pkg::UNI_W-1:0];
        r_item.bad   <= (n_uni <= 0);
    end

    assign o_valid = r_v3;
    assign o_item  = r_item;
endmodule

@@ hdl/iou_queue.sv @@
module iou_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  iou_pkg::t_item i_item,
    output logic           o_valid,
    output iou_pkg::t_item o_item,
    output logic           o_full
);
    localparam int PW = iou_pkg::QPTR_W;

    iou_pkg::t_item r_mem [iou_pkg::QDEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_count;
    logic           r_valid;
    iou_pkg::t_item r_item;
    logic           n_pop;

    assign n_pop   = (r_count != '0);
    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_full  = r_count >= (PW+1)'(iou_pkg::QDEPTH - iou_pkg::FRONT_STAGES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (n_pop) r_rp <= r_rp + 1'b1;
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(n_pop);
            r_valid <= n_pop;
        end
        if (i_push) r_mem[r_wp] <= i_item;
        if (n_pop) r_item <= r_mem[r_rp];
    end
endmodule

@@ hdl/iou_back.sv @@
module iou_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  iou_pkg::t_item                       i_item,
    output logic                                 o_done,
    output logic [iou_pkg::RATIO_W-1:0]          o_iou_ratio,
    output logic [iou_pkg::AREA_W-1:0]           o_overlap_area,
    output logic signed [iou_pkg::UNI_W-1:0]     o_union_area_out,
    output logic                                 o_invalid
);
    localparam int F  = iou_pkg::RATIO_FRAC_BITS;
    localparam int UW = iou_pkg::UNI_W;
    localparam int RW = UW + 1;
    localparam int QW = iou_pkg::RATIO_W;

    logic                 r_pv  [F+1];
    logic [RW-1:0]        r_rem [F+1];
    logic [QW-1:0]        r_q   [F+1];
    logic [UW-1:0]        r_den [F+1];
    logic [iou_pkg::AREA_W-1:0] r_ov [F+1];
    logic [UW-1:0]        r_un  [F+1];
    logic                 r_bad [F+1];

    logic [RW-1:0] n_rem [F+1];
    logic [QW-1:0] n_q   [F+1];
    logic [RW-1:0] n_num, n_den0, n_rs, n_shift [F+1];
    logic [QW:0]   n_qr;

    always_comb begin
        n_den0 = i_item.bad ? RW'(1) : {1'b0, i_item.uni};
        n_num  = RW'(i_item.inter);
        if (n_num >= n_den0) begin
            n_rem[0] = n_num - n_den0;
            n_q[0]   = QW'(1);
        end else begin
            n_rem[0] = n_num;
            n_q[0]   = '0;
        end
        n_shift[0] = '0;
        for (int k = 1; k <= F; k++) begin
            n_shift[k] = {r_rem[k-1][RW-2:0], 1'b0};
            if (n_shift[k] >= {1'b0, r_den[k-1]}) begin
                n_rem[k] = n_shift[k] - {1'b0, r_den[k-1]};
                n_q[k]   = {r_q[k-1][QW-2:0], 1'b1};
            end else begin
                n_rem[k] = n_shift[k];
                n_q[k]   = {r_q[k-1][QW-2:0], 1'b0};
            end
        end
        n_rs = {r_rem[F][RW-2:0], 1'b0};
        n_qr = {1'b0, r_q[F]} + (QW+1)'(n_rs >= {1'b0, r_den[F]});
        if (n_qr > (QW+1)'(1) << F) n_qr = (QW+1)'(1) << F;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= F; k++) r_pv[k] <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_pv[0] <= i_valid;
            for (int k = 1; k <= F; k++) r_pv[k] <= r_pv[k-1];
            o_done <= r_pv[F];
        end
        r_rem[0] <= n_rem[0];
        r_q[0]   <= n_q[0];
        r_den[0] <= n_den0[UW-1:0];
        r_ov[0]  <= i_item.inter;
        r_un[0]  <= i_item.uni;
        r_bad[0] <= i_item.bad;
        for (int k = 1; k <= F; k++) begin
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
            r_den[k] <= r_den[k-1];
            r_ov[k]  <= r_ov[k-1];
            r_un[k]  <= r_un[k-1];
            r_bad[k] <= r_bad[k-1];
        end
        o_iou_ratio      <= r_bad[F] ? '0 : n_qr[QW-1:0];
        o_overlap_area   <= r_ov[F];
        o_union_area_out <= r_un[F];
        o_invalid        <= r_bad[F];
    end
endmodule

@@ hdl/iou_checker.sv @@
`include "assert_macros.svh"
module iou_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 busy,
    input logic                                 o_done,
    input logic [iou_pkg::RATIO_W-1:0]          o_iou_ratio,
    input logic signed [iou_pkg::UNI_W-1:0]     o_union_area_out,
    input logic                                 o_invalid
);
    localparam logic [iou_pkg::RATIO_W-1:0] RATIO_ONE =
        iou_pkg::RATIO_W'(1) << iou_pkg::RATIO_FRAC_BITS;

    `ASSERT_IMPLY(a_invalid_zero, i_clk, i_rst_n, o_done && o_invalid, o_iou_ratio == '0)
    `ASSERT_IMPLY(a_ratio_max, i_clk, i_rst_n, o_done, o_iou_ratio <= RATIO_ONE)
    `ASSERT_IMPLY(a_invalid_sign, i_clk, i_rst_n, o_done, o_invalid == (o_union_area_out <= 0))
    `ASSERT_NEXT(a_reset_idle, i_clk, !i_rst_n, !busy && !o_done)
endmodule

bind box_intersection_over_union_core iou_checker u_iou_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .busy             (busy),
    .o_done           (o_done),
    .o_iou_ratio      (o_iou_ratio),
    .o_union_area_out (o_union_area_out),
    .o_invalid        (o_invalid)
);

@@ sim/box_intersection_over_union_core_tb.sv @@
module box_intersection_over_union_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 23;
    localparam int STALL_LIMIT = 2000;

    typedef logic signed [iou_pkg::COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic [iou_pkg::RATIO_W-1:0]      ratio;
        logic [iou_pkg::AREA_W-1:0]       overlap;
        logic signed [iou_pkg::UNI_W-1:0] uni;
        logic                             invalid;
    } t_score;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    t_coord                           i_a_left, i_a_bottom, i_a_right, i_a_top;
    t_coord                           i_b_left, i_b_bottom, i_b_right, i_b_top;
    logic                             o_done;
    logic [iou_pkg::RATIO_W-1:0]      o_iou_ratio;
    logic [iou_pkg::AREA_W-1:0]       o_overlap_area;
    logic signed [iou_pkg::UNI_W-1:0] o_union_area_out;
    logic                             o_invalid;

    t_score      pending_scores[$];
    int          mismatch_count;
    int          request_count;
    int          score_count;
    int          invalid_count;
    int          overlap_count;
    int          idle_pct;
    int          quiet_cycles;

    box_intersection_over_union_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_a_left         (i_a_left),
        .i_a_bottom       (i_a_bottom),
        .i_a_right        (i_a_right),
        .i_a_top          (i_a_top),
        .i_b_left         (i_b_left),
        .i_b_bottom       (i_b_bottom),
        .i_b_right        (i_b_right),
        .i_b_top          (i_b_top),
        .o_done           (o_done),
        .o_iou_ratio      (o_iou_ratio),
        .o_overlap_area   (o_overlap_area),
        .o_union_area_out (o_union_area_out),
        .o_invalid        (o_invalid)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [iou_pkg::RATIO_W-1:0] iou_fraction(logic [63:0] num,
                                                                 logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = 0;
        r = num;
        if (r >= den) begin
            q = 1;
            r = r - den;
            if (r >= den) r = 0;
        end
        for (int i = 0; i < iou_pkg::RATIO_FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        if ((r << 1) >= den) q = q + 1;
        if (q > (64'd1 << iou_pkg::RATIO_FRAC_BITS)) q = 64'd1 << iou_pkg::RATIO_FRAC_BITS;
        return q[iou_pkg::RATIO_W-1:0];
    endfunction

    function automatic t_score score_pair(t_coord al, t_coord ab, t_coord ar, t_coord at,
                                          t_coord bl, t_coord bb, t_coord br, t_coord bt);
        t_score s;
        longint xl, xh, yl, yh, inter, uni;
        xh = (ar < br) ? ar : br;
        yh = (at < bt) ? at : bt;
        xl = (al > bl) ? al : bl;
        yl = (ab > bb) ? ab : bb;
        inter = 0;
        if (xh > xl && yh > yl) inter = (xh - xl) * (yh - yl);
        uni = (longint'(ar) - al) * (longint'(at) - ab)
            + (longint'(br) - bl) * (longint'(bt) - bb) - inter;
        s.overlap = inter[iou_pkg::AREA_W-1:0];
        s.uni = uni[iou_pkg::UNI_W-1:0];
        s.invalid = (uni <= 0);
        s.ratio = s.invalid ? '0 : iou_fraction(inter, uni);
        return s;
    endfunction

    task automatic send_pair(t_coord al, t_coord ab, t_coord ar, t_coord at,
                             t_coord bl, t_coord bb, t_coord br, t_coord bt);
        t_score s;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_a_left <= al;  i_a_bottom <= ab;  i_a_right <= ar;  i_a_top <= at;
        i_b_left <= bl;  i_b_bottom <= bb;  i_b_right <= br;  i_b_top <= bt;
        do @(posedge i_clk); while (busy);
        s = score_pair(al, ab, ar, at, bl, bb, br, bt);
        pending_scores.push_back(s);
        request_count++;
        if (s.invalid) invalid_count++;
        if (s.overlap != 0) overlap_count++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_score want;
        if (i_rst_n && o_done) begin
            score_count++;
            if (pending_scores.size() == 0) begin
                $display("%0t unexpected result ratio %0d", $time, o_iou_ratio);
                mismatch_count++;
            end else begin
                want = pending_scores.pop_front();
                if (o_iou_ratio !== want.ratio) begin
                    $display("%0t ratio expected %0d actual %0d", $time, want.ratio,
                             o_iou_ratio);
                    mismatch_count++;
                end
                if (o_overlap_area !== want.overlap) begin
                    $display("%0t overlap expected %0d actual %0d", $time, want.overlap,
                             o_overlap_area);
                    mismatch_count++;
                end
                if (o_union_area_out !== want.uni) begin
                    $display("%0t union expected %0d actual %0d", $time, want.uni,
                             o_union_area_out);
                    mismatch_count++;
                end
                if (o_invalid !== want.invalid) begin
                    $display("%0t invalid expected %0b actual %0b", $time, want.invalid,
                             o_invalid);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic t_coord pick_coord();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return t_coord'($urandom_range(200)) - 16'sd100;
            default: return t_coord'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_pair(0, 0, 10, 10, 0, 0, 10, 10);
        send_pair(0, 0, 10, 10, 5, 5, 15, 15);
        send_pair(0, 0, 10, 10, 10, 0, 20, 10);
        send_pair(0, 0, 10, 10, 0, 10, 10, 20);
        send_pair(0, 0, 10, 10, 20, 20, 30, 30);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(10, 10, 0, 0, 0, 0, 10, 10);
        send_pair(10, 10, 0, 0, 10, 10, 0, 0);
        send_pair(10, 0, 0, 10, 0, 0, 5, 5);
        send_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        send_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1);
        send_pair(32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768);
        send_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
        send_pair(0, 0, 3, 1, 0, 0, 1, 3);
        send_pair(0, 0, 2, 1, 0, 0, 1, 1);
        send_pair(-5, -5, -1, -1, -3, -3, 7, 7);
        send_pair(0, 0, 1, 1, -32768, -32768, 32767, 32767);
    endtask

    task automatic test_random(int count);
        t_coord cx, cy, w, h;
        repeat (count) begin
            if ($urandom_range(9) < 7) begin
                cx = pick_coord();
                cy = pick_coord();
                w = t_coord'($urandom_range(($urandom_range(3) == 0) ? 32767 : 300));
                h = t_coord'($urandom_range(($urandom_range(3) == 0) ? 32767 : 300));
                send_pair(cx, cy, cx + w, cy + h,
                          cx + t_coord'($urandom_range(200)) - 16'sd100,
                          cy + t_coord'($urandom_range(200)) - 16'sd100,
                          cx + w + t_coord'($urandom_range(200)) - 16'sd100,
                          cy + h + t_coord'($urandom_range(200)) - 16'sd100);
            end else begin
                send_pair(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                          pick_coord(), pick_coord(), pick_coord(), pick_coord());
            end
        end
    endtask

    initial begin
        start = 1'b0;
        i_rst_n = 1'b0;
        {i_a_left, i_a_bottom, i_a_right, i_a_top} = '0;
        {i_b_left, i_b_bottom, i_b_right, i_b_top} = '0;
        mismatch_count = 0;
        request_count = 0;
        score_count = 0;
        invalid_count = 0;
        overlap_count = 0;
        idle_pct = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        idle_pct = 0;
        test_random(200);
        idle_pct = 62;
        test_random(200);
        idle_pct = 17;
        test_random(220);
        idle_pct = 0;
        test_random(210);
        start <= 1'b0;
        while (pending_scores.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        $display("Scored %0d box pairs, %0d overlapping, %0d with a non-positive union.",
                 score_count, overlap_count, invalid_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
